>>> src/bfba_pkg.sv
package bfba_pkg;

   // Input item command codes
   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_ALLOC = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   // Configuration register word index
   localparam logic REG_BLOCK_COUNT = 1'b0;

   // Fixed field widths
   localparam int COUNT_BITS = 5;
   localparam int PORT_INDEX_BITS = 4;
   localparam int PORT_SIZE_BITS = 16;

   // Controller to datapath commands
   typedef struct packed {
      logic load_we;
      logic clear_marks;
      logic scan_start;
      logic scan_step;
      logic respond;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic count_zero;
      logic scan_last;
   } dp_status_type;

endpackage

>>> src/bfba_ram.sv
module bfba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry into the output register
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> src/bfba_ctrl.sv
module bfba_ctrl
   import bfba_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    req_command,
   input  dp_status_type status,
   output ctl_cmd_type   cmd,
   output logic          busy
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_ALLOC)) begin
               state_in = status.count_zero ? ST_RESP : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode datapath commands
   always_comb begin
      cmd.load_we     = accept && (req_command == CMD_LOAD);
      cmd.clear_marks = accept && (req_command == CMD_CLEAR);
      cmd.scan_start  = accept && (req_command == CMD_ALLOC);
      cmd.scan_step   = (state_ff == ST_SCAN);
      cmd.respond     = (state_ff == ST_RESP);
   end

endmodule

>>> src/bfba_datapath.sv
module bfba_datapath
   import bfba_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ctl_cmd_type                cmd,
   input  logic [COUNT_BITS-1:0]      block_count,
   input  logic [PORT_INDEX_BITS-1:0] req_block_index,
   input  logic [PORT_SIZE_BITS-1:0]  req_size_value,
   output dp_status_type              status,
   output logic                       rsp_valid,
   output logic                       rsp_granted,
   output logic [PORT_INDEX_BITS-1:0] rsp_granted_block
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   logic [COUNT_BITS-1:0] blocks_used;
   logic [SIZE_BITS-1:0]  size_in;
   logic                  load_in_range;
   logic [SIZE_BITS-1:0]  rd_data;

   logic [IDX_W-1:0]      scan_ff;
   logic                  cmp_pending_ff;
   logic [IDX_W-1:0]      cmp_idx_ff;
   logic [SIZE_BITS-1:0]  req_size_ff;
   logic                  found_ff;
   logic [IDX_W-1:0]      best_ff;
   logic [SIZE_BITS-1:0]  best_size_ff;
   logic [NUM_BLOCKS-1:0] occ_ff;
   logic                  take;

   // Saturate the block count to the table depth
   always_comb begin
      if (32'(block_count) > NUM_BLOCKS) begin
         blocks_used = COUNT_BITS'(NUM_BLOCKS);
      end else begin
         blocks_used = block_count;
      end
   end

   assign size_in       = SIZE_BITS'(req_size_value);
   assign load_in_range = (32'(req_block_index) < NUM_BLOCKS);

   assign status.count_zero = (blocks_used == '0);
   assign status.scan_last  = ((32'(scan_ff) + 32'd1) == 32'(blocks_used));

   bfba_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_sizes (
      .clock (clock),
      .we    (cmd.load_we && load_in_range),
      .waddr (IDX_W'(req_block_index)),
      .wdata (size_in),
      .raddr (scan_ff),
      .rdata (rd_data)
   );

   // Advance the scan address and tag the read in flight
   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_pending_ff <= 1'b0;
      end else begin
         cmp_pending_ff <= cmd.scan_step;
      end
      if (cmd.scan_start) begin
         scan_ff     <= '0;
         req_size_ff <= size_in;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + IDX_W'(1);
      end
      cmp_idx_ff <= scan_ff;
   end

   // Keep the smallest free fitting block, lowest index on ties
   assign take = cmp_pending_ff && !occ_ff[cmp_idx_ff] && (rd_data >= req_size_ff) &&
                 (!found_ff || (rd_data < best_size_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         best_ff  <= '0;
      end else if (cmd.scan_start) begin
         found_ff <= 1'b0;
         best_ff  <= '0;
      end else if (take) begin
         found_ff <= 1'b1;
         best_ff  <= cmp_idx_ff;
      end
      if (take) begin
         best_size_ff <= rd_data;
      end
   end

   // Clear all marks, or mark the granted block
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.clear_marks) begin
         occ_ff <= '0;
      end else if (cmd.respond && found_ff) begin
         occ_ff[best_ff] <= 1'b1;
      end
   end

   assign rsp_valid         = cmd.respond;
   assign rsp_granted       = found_ff;
   assign rsp_granted_block = PORT_INDEX_BITS'(best_ff);

`ifndef NO_ASSERTIONS
   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      cmd.respond && found_ff |-> !occ_ff[best_ff])
      else $error("granted block already occupied");

   a_grant_fits: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_size_ff >= req_size_ff)
      else $error("chosen block smaller than request");

   a_grant_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.respond && found_ff |=> occ_ff[$past(best_ff)])
      else $error("granted block not marked occupied");
`endif

endmodule

>>> src/best_fit_block_allocator.sv
// Channel   Ports                                      Transfer
// request   start, busy, req_command/block_index/size  edge with start high, busy low
// result    rsp_valid, rsp_granted, rsp_granted_block  every cycle rsp_valid is high
// config    psel, penable, pwrite, paddr, pwdata, ...  edge with psel, penable, pwrite
//
// Load and clear items complete at the accepting edge; busy stays low.
// A request scans n = min(block_count, NUM_BLOCKS) blocks, one size RAM read per cycle;
// the result strobes in state RESP after states SCAN and LAST (straight from IDLE when n is zero),
// and a new request is accepted once RESP returns to IDLE.
// Synchronous reset frees every block and clears block_count; sizes are not cleared.
// The receiver cannot stall: each result is shown for one cycle only.
module best_fit_block_allocator
   import bfba_pkg::*;
#(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_command,
   input  logic [PORT_INDEX_BITS-1:0] req_block_index,
   input  logic [PORT_SIZE_BITS-1:0]  req_size_value,
   output logic                       rsp_valid,
   output logic                       rsp_granted,
   output logic [PORT_INDEX_BITS-1:0] rsp_granted_block,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   logic [COUNT_BITS-1:0] block_count_ff;
   ctl_cmd_type           cmd;
   dp_status_type         status;
   logic                  reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = (paddr[2] == REG_BLOCK_COUNT);

   // Take register writes on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= '0;
      end else if (psel && penable && pwrite && reg_sel) begin
         block_count_ff <= pwdata[COUNT_BITS-1:0];
      end
   end

   assign prdata = reg_sel ? {{(32 - COUNT_BITS){1'b0}}, block_count_ff} : 32'd0;

   bfba_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .status      (status),
      .cmd         (cmd),
      .busy        (busy)
   );

   bfba_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .block_count       (block_count_ff),
      .req_block_index   (req_block_index),
      .req_size_value    (req_size_value),
      .status            (status),
      .rsp_valid         (rsp_valid),
      .rsp_granted       (rsp_granted),
      .rsp_granted_block (rsp_granted_block)
   );

endmodule

>>> bench/best_fit_block_allocator_test.sv
`timescale 1ns / 100ps

module best_fit_block_allocator_test;
   import bfba_pkg::*;

   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int SCAN_SETTLE_CYCLES = 24;
   localparam int DRAIN_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT = 8;
   localparam int ITEMS_PER_PHASE = 212;
   localparam int NUM_ROWS = 27;

   typedef struct packed {
      logic                       granted;
      logic [PORT_INDEX_BITS-1:0] block;
   } allocation_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [1:0]                 cmd;
      logic [PORT_INDEX_BITS-1:0] idx;
      logic [PORT_SIZE_BITS-1:0]  value;
      logic                       typed;
      logic                       exp_granted;
      logic [PORT_INDEX_BITS-1:0] exp_block;
   } directed_row_type;

   // Directed stimulus; typed expectations only where obvious
   localparam directed_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      // zero count: nothing can be granted
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'h0000, 1'b1, 1'b0, 4'd0},
      // unused command gives no result
      '{ROW_ITEM, CMD_UNUSED, 4'd5,  16'h1234, 1'b0, 1'b0, 4'd0},
      // fill every size entry before any scan
      '{ROW_ITEM, CMD_LOAD,   4'd0,  16'hFFFF, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd1,  16'h0000, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd2,  16'h0064, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd3,  16'h0032, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd4,  16'h0064, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd5,  16'h8000, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd6,  16'h7FFF, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd7,  16'h0001, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd8,  16'h00C8, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd9,  16'h0032, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd10, 16'hAAAA, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd11, 16'h5555, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd12, 16'h0010, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd13, 16'hFFFE, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd14, 16'h0100, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_LOAD,   4'd15, 16'h0064, 1'b0, 1'b0, 4'd0},
      // use the whole table
      '{ROW_CSR,  CMD_LOAD,   4'd0,  16'd16,   1'b0, 1'b0, 4'd0},
      // largest request fits only block zero
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'hFFFF, 1'b1, 1'b1, 4'd0},
      // equal sizes: lowest index first
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'h0064, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'h0064, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
      // clear frees blocks but keeps sizes
      '{ROW_ITEM, CMD_CLEAR,  4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'h0000, 1'b0, 1'b0, 4'd0},
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'hFFFF, 1'b1, 1'b1, 4'd0},
      '{ROW_ITEM, CMD_ALLOC,  4'd0,  16'hFFFF, 1'b1, 1'b0, 4'd0}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_command = CMD_LOAD;
   logic [PORT_INDEX_BITS-1:0] req_block_index = '0;
   logic [PORT_SIZE_BITS-1:0]  req_size_value = '0;
   logic                       rsp_valid;
   logic                       rsp_granted;
   logic [PORT_INDEX_BITS-1:0] rsp_granted_block;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [2:0]                 paddr = '0;
   logic [31:0]                pwdata = '0;
   logic [31:0]                prdata;
   logic                       pready;

   // Shadow state of the allocator
   logic [PORT_SIZE_BITS-1:0]  size_table [NUM_BLOCKS];
   bit                         block_taken [NUM_BLOCKS];
   logic [COUNT_BITS-1:0]      block_count_shadow;

   allocation_type pending_grants [$];
   int             fail_count = 0;
   int             quiet_cycles = 0;

   best_fit_block_allocator #(
      .NUM_BLOCKS(NUM_BLOCKS),
      .SIZE_BITS (SIZE_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_block_index  (req_block_index),
      .req_size_value   (req_size_value),
      .rsp_valid        (rsp_valid),
      .rsp_granted      (rsp_granted),
      .rsp_granted_block(rsp_granted_block),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always #2 clock = ~clock;

   // Apply one item to the shadow state; return 1 if it yields a result
   function automatic bit predict_allocation(input logic [1:0] cmd,
                                             input logic [PORT_INDEX_BITS-1:0] idx,
                                             input logic [PORT_SIZE_BITS-1:0] size,
                                             output allocation_type result);
      int  limit;
      bit  found;
      int  best;
      result = '0;
      found = 1'b0;
      best = 0;
      case (cmd)
         CMD_LOAD: begin
            size_table[idx] = size;
            return 1'b0;
         end
         CMD_CLEAR: begin
            foreach (block_taken[j]) block_taken[j] = 1'b0;
            return 1'b0;
         end
         CMD_ALLOC: begin
            // saturate the count at the table depth
            limit = (block_count_shadow > NUM_BLOCKS) ? NUM_BLOCKS : block_count_shadow;
            for (int j = 0; j < limit; j++) begin
               if (!block_taken[j] && size_table[j] >= size) begin
                  if (!found || size_table[j] < size_table[best]) begin
                     best = j;
                     found = 1'b1;
                  end
               end
            end
            if (found) block_taken[best] = 1'b1;
            result.granted = found;
            result.block = found ? best[PORT_INDEX_BITS-1:0] : '0;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Present one item, hold it until the transfer, then predict
   task automatic send_item(input logic [1:0] cmd,
                            input logic [PORT_INDEX_BITS-1:0] idx,
                            input logic [PORT_SIZE_BITS-1:0] size,
                            input bit typed,
                            input allocation_type typed_result);
      allocation_type predicted;
      bit             has_result;
      @(negedge clock);
      start = 1'b1;
      req_command = cmd;
      req_block_index = idx;
      req_size_value = size;
      do @(posedge clock); while (busy);
      has_result = predict_allocation(cmd, idx, size, predicted);
      if (has_result) pending_grants.push_back(typed ? typed_result : predicted);
   endtask

   task automatic idle_cycles(input int n);
      repeat (n) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // Drain results, let any scan settle, then write block_count
   task automatic write_block_count(input logic [COUNT_BITS-1:0] count);
      logic [31:0] word;
      word = $urandom();
      word[COUNT_BITS-1:0] = count;
      // drop start before waiting so the last item is not taken again
      idle_cycles(1);
      while (pending_grants.size() != 0) @(posedge clock);
      idle_cycles(SCAN_SETTLE_CYCLES);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {REG_BLOCK_COUNT, 2'b00};
      pwdata = word;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      block_count_shadow = count;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   // Mix of uniform, tiny, extreme and byte-range sizes
   function automatic logic [PORT_SIZE_BITS-1:0] random_size();
      case ($urandom_range(0, 3))
         0: return PORT_SIZE_BITS'($urandom_range(0, 65535));
         1: return PORT_SIZE_BITS'($urandom_range(0, 15));
         2: return $urandom_range(0, 1) ? '1 : '0;
         default: return PORT_SIZE_BITS'($urandom_range(0, 255));
      endcase
   endfunction

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      allocation_type want;
      if (!reset && rsp_valid) begin
         if (pending_grants.size() == 0) begin
            $error("result with none expected: granted %0d, granted_block %0d",
                   rsp_granted, rsp_granted_block);
            fail_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_granted !== want.granted) begin
               $error("granted: expected %0d, actual %0d", want.granted, rsp_granted);
               fail_count++;
            end
            if (rsp_granted_block !== want.block) begin
               $error("granted_block: expected %0d, actual %0d",
                      want.block, rsp_granted_block);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: count cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pwrite && pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [COUNT_BITS-1:0] phase_counts [PHASE_COUNT];
      allocation_type        typed_result;
      int                    counted;
      int                    pick;
      bit                    idling;
      bit                    segment_idle;
      logic [1:0]            cmd;

      foreach (size_table[j]) size_table[j] = '0;
      foreach (block_taken[j]) block_taken[j] = 1'b0;
      block_count_shadow = '0;

      // hold reset, release on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // walk the directed table
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (DIRECTED_ROWS[r].kind == ROW_CSR) begin
            write_block_count(DIRECTED_ROWS[r].value[COUNT_BITS-1:0]);
         end else begin
            typed_result.granted = DIRECTED_ROWS[r].exp_granted;
            typed_result.block = DIRECTED_ROWS[r].exp_block;
            send_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].value,
                      DIRECTED_ROWS[r].typed, typed_result);
         end
      end

      // random phases: extremes, saturation and random counts
      phase_counts[0] = 5'd16;
      phase_counts[1] = 5'd0;
      phase_counts[2] = 5'd31;
      phase_counts[3] = 5'd1;
      phase_counts[4] = COUNT_BITS'($urandom_range(0, 31));
      phase_counts[5] = 5'd17;
      phase_counts[6] = COUNT_BITS'($urandom_range(2, 15));
      phase_counts[7] = 5'd16;

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_block_count(phase_counts[p]);
         idling = (p != PHASE_COUNT - 1);
         segment_idle = 1'b0;
         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            // switch between idle and back-to-back stretches
            if (counted % 30 == 0) segment_idle = idling && ($urandom_range(0, 2) != 0);
            if (segment_idle && $urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 9));
            pick = $urandom_range(0, 99);
            if (pick < 50) cmd = CMD_ALLOC;
            else if (pick < 82) cmd = CMD_LOAD;
            else if (pick < 88) cmd = CMD_CLEAR;
            else cmd = CMD_UNUSED;
            send_item(cmd, PORT_INDEX_BITS'($urandom_range(0, NUM_BLOCKS - 1)),
                      random_size(), 1'b0, '0);
            counted++;
         end
      end

      // drop start, drain, then let the block settle
      @(negedge clock);
      start = 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
